@@ design/quic_frame_header_parser_macros.svh @@
// Assertion macros for the QUIC frame header parser
`ifndef QUIC_FRAME_HEADER_PARSER_MACROS_SVH
`define QUIC_FRAME_HEADER_PARSER_MACROS_SVH
// Assert that an antecedent implies a consequent in the same cycle.
`define QFP_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Assert that an antecedent implies a consequent in the next cycle.
`define QFP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`endif

@@ design/qfp_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// QUIC frame parser package
// Phase codes, status codes and the result record type.
// ----------------------------------------------------------------------------
package qfp_pkg;
    localparam int MAX_FRAMES_DEF    = 64;
    localparam int POSITION_BITS_DEF = 16;
    localparam int V62               = 62;

    localparam logic [3:0] PH_IDLE  = 4'd0;
    localparam logic [3:0] PH_TYPE  = 4'd1;
    localparam logic [3:0] PH_F1    = 4'd2;
    localparam logic [3:0] PH_F2    = 4'd3;
    localparam logic [3:0] PH_F3    = 4'd4;
    localparam logic [3:0] PH_F4    = 4'd5;
    localparam logic [3:0] PH_SKIPV = 4'd6;
    localparam logic [3:0] PH_SKIPB = 4'd7;
    localparam logic [3:0] PH_ERR   = 4'd8;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_TRUNC   = 2'd1;
    localparam logic [1:0] ST_INVALID = 2'd2;
    localparam logic [1:0] ST_FULL    = 2'd3;

    localparam logic [5:0] FT_PING    = 6'h01;
    localparam logic [5:0] FT_ACK     = 6'h02;
    localparam logic [5:0] FT_ACK_ECN = 6'h03;
    localparam logic [5:0] FT_RESET   = 6'h04;
    localparam logic [5:0] FT_DGRAM   = 6'h30;
    localparam logic [5:0] FT_DGRAM_L = 6'h31;

    typedef struct packed {
        logic        kind;
        logic [5:0]  ftype;
        logic [3:0]  flags;
        logic [61:0] ident;
        logic [61:0] position;
        logic [61:0] length;
        logic [61:0] extra;
        logic [15:0] pstart;
        logic [15:0] psize;
        logic [6:0]  count;
        logic [1:0]  status;
    } rec_t;
endpackage

@@ design/qfp_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// QUIC frame parser core
// Per-byte varint decode and frame state machine; yields up to two records.
// ----------------------------------------------------------------------------
module qfp_core #(
    parameter int MAX_FRAMES    = qfp_pkg::MAX_FRAMES_DEF,
    parameter int POSITION_BITS = qfp_pkg::POSITION_BITS_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          step,
    input  logic [7:0]    data_byte,
    input  logic [15:0]   packet_length,
    output logic          has_desc,
    output logic          has_end,
    output qfp_pkg::rec_t desc,
    output qfp_pkg::rec_t endrec
);
    import qfp_pkg::*;
    localparam int PB = POSITION_BITS;
    localparam int CW = $clog2(MAX_FRAMES + 1);
    localparam logic [PB-1:0] PMAX = {PB{1'b1}};

    logic [PB-1:0] pos_reg, pos_next, size_reg, size_next;
    logic [3:0]    phase_reg, phase_next;
    logic [61:0]   acc_reg, acc_next;
    logic [2:0]    vleft_reg, vleft_next;
    logic [5:0]    type_reg, type_next;
    logic [3:0]    flags_reg, flags_next;
    logic [61:0]   id_reg, id_next, po_reg, po_next, len_reg, len_next, ex_reg, ex_next;
    logic [PB-1:0] ps_reg, ps_next;
    logic [63:0]   skv_reg, skv_next;
    logic [PB-1:0] skb_reg, skb_next;
    logic [CW-1:0] fr_reg, fr_next;
    logic [1:0]    err_reg, err_next;

    logic [61:0]   v;
    logic [PB:0]   nxt;
    logic [PB-1:0] remain;
    logic          stream, ack;
    logic [7:0]    b;
    logic          done;
    logic          fin, fin_ex;
    logic [PB-1:0] dsize;
    logic [PB-1:0] lsat;

    always_comb
    begin
        pos_next   = pos_reg;    size_next  = size_reg;   phase_next = phase_reg;
        acc_next   = acc_reg;    vleft_next = vleft_reg;  type_next  = type_reg;
        flags_next = flags_reg;  id_next    = id_reg;     po_next    = po_reg;
        len_next   = len_reg;    ex_next    = ex_reg;     ps_next    = ps_reg;
        skv_next   = skv_reg;    skb_next   = skb_reg;    fr_next    = fr_reg;
        err_next   = err_reg;
        has_desc = 1'b0;
        has_end  = 1'b0;
        fin = 1'b0; fin_ex = 1'b0;
        dsize = '0;
        b = data_byte;
        v = '0;
        done = 1'b0;
        if (phase_next == PH_IDLE || phase_next > PH_ERR)
        begin
            if (PB < 16 && packet_length > 16'(PMAX))
                lsat = PMAX;
            else
                lsat = PB'(packet_length);
            size_next  = (lsat == '0) ? PB'(1) : lsat;
            pos_next   = '0;
            fr_next    = '0;
            err_next   = ST_OK;
            vleft_next = '0;
            phase_next = PH_TYPE;
        end
        else
            lsat = '0;
        nxt    = {1'b0, pos_next} + 1'b1;
        remain = size_next - nxt[PB-1:0];
        stream = (type_next[5:3] == 3'b001);
        ack    = (type_next == FT_ACK || type_next == FT_ACK_ECN);
        if (phase_next == PH_ERR)
        begin
        end
        else if (phase_next == PH_SKIPB)
        begin
            if (skb_next != '0) skb_next = skb_next - 1'b1;
            if (skb_next == '0) phase_next = PH_TYPE;
        end
        else if (phase_next == PH_TYPE && vleft_next == '0 && b == 8'd0)
        begin
        end
        else
        begin
            if (vleft_next == '0)
            begin
                acc_next = {56'd0, b[5:0]};
                case (b[7:6])
                    2'd0: vleft_next = 3'd0;
                    2'd1: vleft_next = 3'd1;
                    2'd2: vleft_next = 3'd3;
                    default: vleft_next = 3'd7;
                endcase
            end
            else
            begin
                acc_next   = {acc_next[53:0], b};
                vleft_next = vleft_next - 1'b1;
            end
            done = (vleft_next == '0);
            v = acc_next;
        end
        if (done)
        begin
            case (phase_next)
                PH_TYPE:
                begin
                    if (v > 62'hFFFFFFFF)
                    begin
                        err_next = ST_INVALID; phase_next = PH_ERR;
                    end
                    else if (32'(fr_next) >= MAX_FRAMES)
                    begin
                        err_next = ST_FULL; phase_next = PH_ERR;
                    end
                    else
                    begin
                        type_next = v[5:0]; flags_next = '0;
                        id_next = '0; po_next = '0; len_next = '0; ex_next = '0;
                        ps_next = '0;
                        if (v == 62'(FT_PING))
                            has_desc = 1'b1;
                        else if (v >= 62'h08 && v <= 62'h0F)
                        begin
                            flags_next = {1'b0, v[2:0]}; phase_next = PH_F1;
                        end
                        else if (v == 62'(FT_ACK) || v == 62'(FT_ACK_ECN))
                        begin
                            flags_next = v[0] ? 4'd8 : 4'd0; phase_next = PH_F1;
                        end
                        else if (v == 62'(FT_RESET))
                            phase_next = PH_F1;
                        else if (v == 62'(FT_DGRAM))
                            fin = 1'b1;
                        else if (v == 62'(FT_DGRAM_L))
                        begin
                            flags_next = 4'd2; phase_next = PH_F1;
                        end
                        else
                        begin
                            err_next = ST_INVALID; phase_next = PH_ERR;
                        end
                    end
                end
                PH_F1:
                begin
                    if (type_next == FT_DGRAM_L)
                    begin
                        len_next = v; fin = 1'b1; fin_ex = 1'b1;
                    end
                    else
                    begin
                        id_next = v;
                        if (stream && type_next[2]) phase_next = PH_F2;
                        else if (stream && type_next[1]) phase_next = PH_F3;
                        else if (stream) fin = 1'b1;
                        else phase_next = PH_F2;
                    end
                end
                PH_F2:
                begin
                    if (stream)
                    begin
                        po_next = v;
                        if (type_next[1]) phase_next = PH_F3;
                        else fin = 1'b1;
                    end
                    else
                    begin
                        if (ack) po_next = v; else ex_next = v;
                        phase_next = PH_F3;
                    end
                end
                PH_F3:
                begin
                    len_next = v;
                    if (stream)
                    begin
                        fin = 1'b1; fin_ex = 1'b1;
                    end
                    else if (ack) phase_next = PH_F4;
                    else has_desc = 1'b1;
                end
                PH_F4:
                begin
                    ex_next  = v;
                    ps_next  = nxt[PB-1:0];
                    skv_next = {1'b0, len_next, 1'b0} +
                               ((type_next == FT_ACK_ECN) ? 64'd3 : 64'd0);
                    if (skv_next == '0) has_desc = 1'b1;
                    else phase_next = PH_SKIPV;
                end
                PH_SKIPV:
                begin
                    skv_next = skv_next - 1'b1;
                    if (skv_next == '0)
                    begin
                        has_desc = 1'b1;
                        dsize = nxt[PB-1:0] - ps_next;
                    end
                end
                default:
                begin
                end
            endcase
        end
        if (fin)
        begin
            if (!fin_ex) len_next = 62'(remain);
            if (len_next > 62'(remain))
            begin
                err_next = ST_TRUNC; phase_next = PH_ERR;
            end
            else
            begin
                ps_next  = nxt[PB-1:0];
                skb_next = len_next[PB-1:0];
                dsize    = len_next[PB-1:0];
                has_desc = 1'b1;
            end
        end
        if (has_desc)
        begin
            fr_next    = fr_next + 1'b1;
            phase_next = (fin && skb_next != '0) ? PH_SKIPB : PH_TYPE;
        end
        desc.kind = 1'b0; desc.ftype = type_next; desc.flags = flags_next;
        desc.ident = id_next; desc.position = po_next; desc.length = len_next;
        desc.extra = ex_next; desc.pstart = 16'(ps_next); desc.psize = 16'(dsize);
        desc.count = 7'(fr_next); desc.status = ST_OK;
        endrec = '0;
        endrec.kind = 1'b1;
        if (nxt >= {1'b0, size_next})
        begin
            if (err_next == ST_OK && (phase_next != PH_TYPE || vleft_next != '0))
                err_next = ST_TRUNC;
            endrec.count  = (err_next == ST_OK || err_next == ST_FULL) ? 7'(fr_next) : 7'd0;
            endrec.status = err_next;
            has_end    = 1'b1;
            phase_next = PH_IDLE;
            vleft_next = '0;
            pos_next   = '0;
        end
        else
            pos_next = nxt[PB-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= '0; size_reg <= '0; phase_reg <= PH_IDLE; acc_reg <= '0;
            vleft_reg <= '0; type_reg <= '0; flags_reg <= '0; id_reg <= '0;
            po_reg <= '0; len_reg <= '0; ex_reg <= '0; ps_reg <= '0;
            skv_reg <= '0; skb_reg <= '0; fr_reg <= '0; err_reg <= ST_OK;
        end
        else if (step)
        begin
            pos_reg <= pos_next; size_reg <= size_next; phase_reg <= phase_next;
            acc_reg <= acc_next; vleft_reg <= vleft_next; type_reg <= type_next;
            flags_reg <= flags_next; id_reg <= id_next; po_reg <= po_next;
            len_reg <= len_next; ex_reg <= ex_next; ps_reg <= ps_next;
            skv_reg <= skv_next; skb_reg <= skb_next; fr_reg <= fr_next;
            err_reg <= err_next;
        end
    end
endmodule

@@ design/qfp_outq.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// QUIC frame parser output queue
// Four-entry record queue; stalls input when two slots are not free.
// ----------------------------------------------------------------------------
module qfp_outq (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push_a,
    input  qfp_pkg::rec_t rec_a,
    input  logic          push_b,
    input  qfp_pkg::rec_t rec_b,
    output logic          room,
    output logic          out_valid,
    input  logic          out_stall,
    output qfp_pkg::rec_t out_rec
);
    import qfp_pkg::*;
    rec_t       mem [4];
    logic [1:0] wp_reg, rp_reg;
    logic [2:0] cnt_reg, cnt_next;
    logic       pop;
    logic [1:0] wp1;

    assign pop       = out_valid && !out_stall;
    assign out_valid = (cnt_reg != 3'd0);
    assign out_rec   = mem[rp_reg];
    assign room      = (cnt_reg <= 3'd2);
    assign wp1       = wp_reg + 2'(push_a);
    assign cnt_next  = cnt_reg + 3'(push_a) + 3'(push_b) - 3'(pop);

    always_ff @(posedge clk)
    begin
        if (push_a) mem[wp_reg] <= rec_a;
        if (push_b) mem[wp1] <= rec_b;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg <= '0; rp_reg <= '0; cnt_reg <= '0;
        end
        else
        begin
            wp_reg  <= wp_reg + 2'(push_a) + 2'(push_b);
            rp_reg  <= rp_reg + 2'(pop);
            cnt_reg <= cnt_next;
        end
    end

    `include "quic_frame_header_parser_macros.svh"
    `QFP_ASSERT_IMPL(a_no_over, clk, rst_n, 1'b1, cnt_reg <= 3'd4, "queue overflow")
    `QFP_ASSERT_IMPL(a_push_room, clk, rst_n, push_a || push_b, cnt_reg <= 3'd2 || pop, "push without room")
    `QFP_ASSERT_NEXT(a_cnt, clk, rst_n, 1'b1, cnt_reg == $past(cnt_next), "count mismatch")
endmodule

@@ design/quic_frame_header_parser.sv @@
`timescale 1ns / 1ps
// Records are registered in the output queue before they appear on the outputs.
// Throughput: one byte per cycle while the four-record output queue has two free slots.
// A byte may yield up to two records (descriptor, then end record).
// Reset: rst_n asynchronous, clears parser state to idle and empties the queue.
// ----------------------------------------------------------------------------
// QUIC frame header parser
// Byte-serial QUIC frame parser emitting frame descriptors and end records.
// ----------------------------------------------------------------------------
module quic_frame_header_parser #(
    parameter int MAX_FRAMES    = qfp_pkg::MAX_FRAMES_DEF,
    parameter int POSITION_BITS = qfp_pkg::POSITION_BITS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  data_byte,
    input  logic [15:0] packet_length,
    output logic        out_valid,
    input  logic        out_stall,
    output logic        record_kind,
    output logic [5:0]  frame_type,
    output logic [3:0]  frame_flags,
    output logic [61:0] ident_value,
    output logic [61:0] position_value,
    output logic [61:0] length_value,
    output logic [61:0] extra_value,
    output logic [15:0] payload_start,
    output logic [15:0] payload_size,
    output logic [6:0]  frame_count,
    output logic [1:0]  parse_status
);
    import qfp_pkg::*;
    logic  step, room, hd, he;
    rec_t  d, e, r;

    assign in_stall = !room;
    assign step     = in_valid && room;

    qfp_core #(.MAX_FRAMES(MAX_FRAMES), .POSITION_BITS(POSITION_BITS)) u_core (
        .clk(clk), .rst_n(rst_n), .step(step), .data_byte(data_byte),
        .packet_length(packet_length), .has_desc(hd), .has_end(he),
        .desc(d), .endrec(e)
    );

    qfp_outq u_q (
        .clk(clk), .rst_n(rst_n),
        .push_a(step && (hd || he)), .rec_a(hd ? d : e),
        .push_b(step && hd && he), .rec_b(e),
        .room(room), .out_valid(out_valid), .out_stall(out_stall), .out_rec(r)
    );

    assign record_kind    = r.kind;
    assign frame_type     = r.ftype;
    assign frame_flags    = r.flags;
    assign ident_value    = r.ident;
    assign position_value = r.position;
    assign length_value   = r.length;
    assign extra_value    = r.extra;
    assign payload_start  = r.pstart;
    assign payload_size   = r.psize;
    assign frame_count    = r.count;
    assign parse_status   = r.status;
endmodule
